// ===== sv/zscore_standardizer_core_defines.svh =====
// Assertion macros for the z-score standardizer.
`ifndef ZSCORE_STANDARDIZER_CORE_DEFINES_SVH
`define ZSCORE_STANDARDIZER_CORE_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define ZSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("zss check failed");

// Next-cycle implication under an active-low reset.
`define ZSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("zss check failed");

`endif

// ===== sv/zss_pkg.sv =====
package zss_pkg;

  localparam int unsigned MAX_COUNT_DEF = 1048576;
  localparam int unsigned CHANNELS_DEF  = 2;

  localparam int SAMPLE_W   = 16;
  localparam int OP_W       = 2;
  localparam int DEV_W      = 55;
  localparam int SQ_W       = 34;
  localparam int DIFF_W     = 17;
  localparam int STD_W      = 16;
  localparam int ROOT_IN_W  = 32;
  localparam int DEV_Q_BITS = 32;
  localparam int Z_Q_BITS   = 17;
  localparam int QUO_W      = DEV_Q_BITS + 1;
  localparam int KW         = 6;

  localparam logic [OP_W-1:0] OP_SUM  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEV  = 2'd1;
  localparam logic [OP_W-1:0] OP_NORM = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

  localparam logic [STD_W-1:0] STD_ONE = 16'd256;
  localparam logic [STD_W-1:0] STD_MAX = 16'hFFFF;

  localparam logic [SAMPLE_W-1:0] Z_POS_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] Z_NEG_MAX = 16'h8000;
  localparam logic [Z_Q_BITS-1:0] Q_POS_LIM = 17'd32767;
  localparam logic [Z_Q_BITS-1:0] Q_NEG_LIM = 17'd32768;

endpackage

// ===== sv/zss_div.sv =====
module zss_div #(
  parameter int NW = 58,
  parameter int DW = 25,
  parameter int QW = 33,
  parameter int KBW = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [KBW-1:0] k_i,
  output logic           done_o,
  output logic [QW-1:0]  quo_o
);

  logic [NW-1:0]  r_q, ds_q;
  logic [QW-1:0]  q_q;
  logic [KBW-1:0] k_q;
  logic           busy_q, done_q;
  logic           ge;

  assign ge     = r_q >= ds_q;
  assign done_o = done_q;
  assign quo_o  = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= busy_q && (k_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= k_i;
      end else if (busy_q) begin
        if (k_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          k_q <= k_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q  <= num_i;
      ds_q <= NW'(den_i) << k_i;
      q_q  <= '0;
    end else if (busy_q) begin
      if (ge) begin
        r_q <= r_q - ds_q;
      end
      q_q  <= {q_q[QW-2:0], ge};
      ds_q <= ds_q >> 1;
    end
  end

endmodule

// ===== sv/zss_sqrt.sv =====
module zss_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [zss_pkg::ROOT_IN_W-1:0] val_i,
  output logic                          done_o,
  output logic [zss_pkg::STD_W-1:0]     root_o
);
  import zss_pkg::*;

  logic [ROOT_IN_W-1:0] v_q, res_q, bit_q;
  logic [ROOT_IN_W:0]   trial;
  logic                 done_q, busy, take;

  assign busy   = |bit_q;
  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign take   = {1'b0, v_q} >= trial;
  assign done_o = done_q;
  assign root_o = res_q[STD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && bit_q[0];
      if (start_i) begin
        bit_q <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
      end else if (busy) begin
        bit_q <= bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
    end else if (busy) begin
      if (take) begin
        v_q   <= v_q - trial[ROOT_IN_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

endmodule

// ===== sv/zscore_standardizer_core.sv =====
// Channel | Direction | Handshake                | Payload
// in      | in        | in_valid_i / in_stall_o  | op_i, channel_i, sample_i, first_i
// out     | out       | out_valid_o / out_stall_i| zvalue_o, out_channel_o, saturated_o
//
// One request at a time. Sum pass: accumulate, then the 18-step divider.
// Deviation pass: multiply, add, 33-step divide, 16-step root.
// Normalize pass: the 18-step divider, plus output wait.
// Reset clears all statistics at once (deviation 1.0); no clearing pass.
// While the output register is full and stalled, a finished result waits in ST_EMIT and new requests stall.
module zscore_standardizer_core #(
  parameter int unsigned MAX_COUNT = zss_pkg::MAX_COUNT_DEF,
  parameter int unsigned CHANNELS  = zss_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [zss_pkg::OP_W-1:0]            op_i,
  input  logic                                channel_i,
  input  logic signed [zss_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                first_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [zss_pkg::SAMPLE_W-1:0] zvalue_o,
  output logic                                out_channel_o,
  output logic                                saturated_o
);
  import zss_pkg::*;

  localparam int CW  = $clog2(MAX_COUNT + 1);
  localparam int SW  = CW + SAMPLE_W;
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DNW = (CW > STD_W) ? CW : STD_W;
  localparam int NW0 = (DEV_W > SW) ? DEV_W : SW;
  localparam int DVW = (NW0 > DNW + QUO_W) ? NW0 : DNW + QUO_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_SQ, ST_DACC, ST_DIV, ST_SQRT, ST_EMIT
  } state_e;

  state_e state_q;

  logic signed [SW-1:0]       sum_q  [CHANNELS];
  logic [CW-1:0]              cnt_q  [CHANNELS];
  logic [DEV_W-1:0]           dev_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] mean_q [CHANNELS];
  logic [STD_W-1:0]           std_q  [CHANNELS];

  logic [OP_W-1:0]            op_q;
  logic [CHW-1:0]             ch_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       first_q, neg_q;
  logic signed [DIFF_W-1:0]   d_q;
  logic [SQ_W-1:0]            sq_q;

  logic                       div_start_q, div_done;
  logic [DVW-1:0]             div_num_q;
  logic [DNW-1:0]             div_den_q;
  logic [KW-1:0]              div_k_q;
  logic [QUO_W-1:0]           div_q;

  logic                       sqrt_start_q, sqrt_done;
  logic [ROOT_IN_W-1:0]       sqrt_val_q;
  logic [STD_W-1:0]           root;

  logic [CW-1:0]              cnt_base, cnt_inc;
  logic signed [SW-1:0]       sum_base, sum_new;
  logic [SW-1:0]              sum_mag;
  logic                       room;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          diff_mag;
  logic [DEV_W-1:0]           dev_base, dev_new;
  logic [DEV_W:0]             dev_sum;
  logic [Z_Q_BITS-1:0]        q17;
  logic                       zovf, zsat;
  logic [SAMPLE_W-1:0]        zval, qneg;

  always_comb begin
    cnt_base = first_q ? '0 : cnt_q[ch_q];
    sum_base = first_q ? '0 : sum_q[ch_q];
    cnt_inc  = cnt_base + 1'b1;
    sum_new  = sum_base + SW'(x_q);
    sum_mag  = sum_new[SW-1] ? SW'(-sum_new) : SW'(sum_new);
    room     = cnt_base < CW'(MAX_COUNT);
    diff     = DIFF_W'(x_q) - DIFF_W'(mean_q[ch_q]);
    diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    dev_base = first_q ? '0 : dev_q[ch_q];
    dev_sum  = {1'b0, dev_base} + (DEV_W + 1)'(sq_q);
    dev_new  = dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];
    q17      = div_q[Z_Q_BITS-1:0];
    zovf     = div_q[Z_Q_BITS];
    qneg     = SAMPLE_W'(-q17);
    if (neg_q) begin
      zsat = zovf || (q17 > Q_NEG_LIM);
      zval = zsat ? Z_NEG_MAX : qneg;
    end else begin
      zsat = zovf || (q17 > Q_POS_LIM);
      zval = zsat ? Z_POS_MAX : q17[SAMPLE_W-1:0];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  zss_div #(
    .NW (DVW),
    .DW (DNW),
    .QW (QUO_W),
    .KBW(KW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .k_i    (div_k_q),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  zss_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start_q),
    .val_i  (sqrt_val_q),
    .done_o (sqrt_done),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      out_valid_o  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        dev_q[i]  <= '0;
        mean_q[i] <= '0;
        std_q[i]  <= STD_ONE;
      end
    end else begin
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      if (out_valid_o && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (op_i != OP_NOP) && (32'(channel_i) < CHANNELS)) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          unique case (op_q)
            OP_SUM: begin
              sum_q[ch_q] <= room ? sum_new : sum_base;
              cnt_q[ch_q] <= room ? cnt_inc : cnt_base;
              neg_q       <= sum_new[SW-1];
              div_num_q   <= DVW'(sum_mag) + DVW'(cnt_inc >> 1);
              div_den_q   <= DNW'(cnt_inc);
              div_k_q     <= KW'(Z_Q_BITS);
              div_start_q <= room;
              state_q     <= room ? ST_DIV : ST_IDLE;
            end
            OP_DEV: begin
              d_q     <= diff;
              state_q <= ST_SQ;
            end
            OP_NORM: begin
              neg_q       <= diff[DIFF_W-1];
              div_num_q   <= DVW'({diff_mag, 8'b0}) + DVW'(std_q[ch_q] >> 1);
              div_den_q   <= DNW'(std_q[ch_q]);
              div_k_q     <= KW'(Z_Q_BITS);
              div_start_q <= 1'b1;
              state_q     <= ST_DIV;
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_SQ: begin
          sq_q    <= SQ_W'(d_q * d_q);
          state_q <= ST_DACC;
        end
        ST_DACC: begin
          dev_q[ch_q] <= dev_new;
          if (cnt_q[ch_q] == '0) begin
            std_q[ch_q] <= STD_ONE;
            state_q     <= ST_IDLE;
          end else begin
            div_num_q   <= DVW'(dev_new);
            div_den_q   <= DNW'(cnt_q[ch_q]);
            div_k_q     <= KW'(DEV_Q_BITS);
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            unique case (op_q)
              OP_SUM: begin
                mean_q[ch_q] <= neg_q ? qneg : q17[SAMPLE_W-1:0];
                state_q      <= ST_IDLE;
              end
              OP_DEV: begin
                if (div_q[DEV_Q_BITS]) begin
                  std_q[ch_q] <= STD_MAX;
                  state_q     <= ST_IDLE;
                end else begin
                  sqrt_val_q   <= div_q[ROOT_IN_W-1:0];
                  sqrt_start_q <= 1'b1;
                  state_q      <= ST_SQRT;
                end
              end
              default: state_q <= ST_EMIT;
            endcase
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            std_q[ch_q] <= (root == '0) ? STD_ONE : root;
            state_q     <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o   <= 1'b1;
            zvalue_o      <= zval;
            out_channel_o <= ch_q[0];
            saturated_o   <= zsat;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      op_q    <= op_i;
      ch_q    <= CHW'(channel_i);
      x_q     <= sample_i;
      first_q <= first_i;
    end
  end

endmodule

// ===== sv/zss_checker.sv =====
`include "zscore_standardizer_core_defines.svh"

module zss_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [zss_pkg::OP_W-1:0]            op_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [zss_pkg::SAMPLE_W-1:0] zvalue_o,
  input logic                                saturated_o
);
  import zss_pkg::*;

  `ZSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(zvalue_o))
  `ZSS_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o && (op_i != OP_NOP), in_stall_o)
  `ZSS_ASSERT_IMP(a_sat_clip, clk_i, rst_ni, out_valid_o && saturated_o, zvalue_o == Z_POS_MAX || zvalue_o == Z_NEG_MAX)
  `ZSS_ASSERT_IMP(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind zscore_standardizer_core zss_checker u_zss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .op_i       (op_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .zvalue_o   (zvalue_o),
  .saturated_o(saturated_o)
);
